### hdl/ppas_pkg.sv
// Shared types, constants and helper functions of the pulse pile-up amplitude solver.
`default_nettype none
package ppas_pkg;

  localparam int QW     = 32;  // carried width of a charge, at least CHARGE_BITS
  localparam int GW     = 16;  // Gaussian fraction, Q16
  localparam int PW     = 24;  // polynomial fraction, Q16, signed
  localparam int ACC_W  = 40;  // Horner accumulator
  localparam int MAG_W  = 60;  // magnitude of a dividend
  localparam int AW     = 32;  // amplitude
  localparam int PRODW  = PW + AW;
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int FIFO_DEPTH = 4;

  localparam logic [0:0] REG_SLEW_OFFSET = 1'b0;
  localparam logic [0:0] REG_SLEW_SLOPE  = 1'b1;

  localparam logic signed [16:0] GAUSS_SHIFT = 17'sd1324;
  localparam logic [15:0] GAUSS_INV2S2 = 16'd56084;
  localparam logic [16:0] LOG2E        = 17'd94548;
  localparam logic [15:0] GAUSS_NORM   = 16'd46531;

  localparam logic signed [ACC_W-1:0] QUAD_K0  = 40'sd1108101562;
  localparam logic signed [ACC_W-1:0] QUAD_K1  = 40'sd76450418;
  localparam logic signed [ACC_W-1:0] QUAD_K2  = 40'sd2055571;
  localparam logic signed [ACC_W-1:0] CUBIC_K0 = 40'sd274491360;
  localparam logic signed [ACC_W-1:0] CUBIC_K1 = 40'sd11755326;
  localparam logic signed [ACC_W-1:0] CUBIC_K2 = 40'sd360605;
  localparam logic signed [ACC_W-1:0] CUBIC_K3 = 40'sd6335;

  localparam logic signed [AW-1:0] AMP_MAX = 32'sh7fffffff;
  localparam logic signed [AW-1:0] AMP_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0][QW-1:0] q;
    logic [2:0][GW-1:0] g;
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] c0;
    logic signed [PW-1:0] p1;
    logic               zero_det;
  } item_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [GW-1:0]    d;
  } div_in_t;

  typedef struct packed {
    logic signed [AW-1:0] val;
    logic                 is_neg;
  } div_out_t;

  // 2^(-k/16) in Q16.
  function automatic logic [16:0] exp2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // One Horner step: k + floor(acc * t / 256).
  function automatic logic signed [ACC_W-1:0] horner_step(
    input logic signed [ACC_W-1:0] k,
    input logic signed [ACC_W-1:0] acc,
    input logic signed [15:0]      t);
    logic signed [ACC_W+15:0] prod;
    logic signed [ACC_W+15:0] sh;
    prod = acc * t;
    sh   = prod >>> 8;
    return k + sh[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/ppas_front.sv
// Front pipeline: time slew, Gaussian and polynomial fractions, singular-system check.
`default_nettype none
module ppas_front import ppas_pkg::*; #(
  parameter int CHARGE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CHARGE_BITS-1:0] early_charge,
  input  wire logic [CHARGE_BITS-1:0] peak_charge,
  input  wire logic [CHARGE_BITS-1:0] late_charge,
  input  wire logic signed [15:0]     slew_offset,
  input  wire logic signed [23:0]     slew_slope,
  input  wire logic                   q_full,
  output logic                        push,
  output item_t                       push_item
);

  localparam int NS    = 9;
  localparam int MW    = 25 + CHARGE_BITS;
  localparam int SUMW  = MW + 1;

  logic adv;
  logic [NS:1] fv;

  logic [2:0][QW-1:0] q_d [1:NS];
  logic signed [MW-1:0] prod [3];
  logic signed [15:0] t_d [3:5][3];
  logic [31:0] uu [3];
  logic [22:0] z [3];
  logic [22:0] w [3];
  logic [11:0] dr [3];
  logic [16:0] tv [3];
  logic [6:0]  n7 [3];
  logic [16:0] e [3];
  logic [GW-1:0] g [3];
  logic signed [ACC_W-1:0] qa1 [2];
  logic signed [ACC_W-1:0] qa0 [6:9][2];
  logic signed [ACC_W-1:0] ca2, ca1;
  logic signed [ACC_W-1:0] ca0 [6:9];

  logic signed [MW-1:0]   sh [3];
  logic signed [SUMW-1:0] sum [3];
  logic signed [15:0]     t_next [3];
  logic signed [16:0]     u [3];
  logic signed [33:0]     usq [3];
  logic [47:0] zp [3];
  logic [39:0] wp [3];
  logic [3:0]  idx [3];
  logic [11:0] diff [3];
  logic [23:0] drp [3];
  logic [16:0] m [3];
  logic [32:0] gp [3];
  logic [2:0][CHARGE_BITS-1:0] qin;

  localparam logic signed [SUMW-1:0] T_MAX = SUMW'(32767);
  localparam logic signed [SUMW-1:0] T_MIN = SUMW'(-32768);

  assign adv      = !fv[NS] || !q_full;
  assign in_ready = adv;
  assign push     = fv[NS] && !q_full;
  assign qin      = {late_charge, peak_charge, early_charge};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sh[l]  = prod[l] >>> 20;
      sum[l] = SUMW'(sh[l]) + SUMW'(slew_offset);
      if (sum[l] > T_MAX) begin
        t_next[l] = 16'sh7fff;
      end else if (sum[l] < T_MIN) begin
        t_next[l] = 16'sh8000;
      end else begin
        t_next[l] = sum[l][15:0];
      end
      u[l]    = 17'(t_d[3][l]) + GAUSS_SHIFT;
      usq[l]  = u[l] * u[l];
      zp[l]   = uu[l] * GAUSS_INV2S2;
      wp[l]   = z[l] * LOG2E;
      idx[l]  = w[l][15:12];
      diff[l] = 12'(exp2_tab({1'b0, idx[l]}) - exp2_tab({1'b0, idx[l]} + 5'd1));
      drp[l]  = diff[l] * w[l][11:0];
      m[l]    = tv[l] - {5'd0, dr[l]};
      gp[l]   = GAUSS_NORM * e[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (adv) begin
      fv <= {fv[NS-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        q_d[1][l] <= QW'(qin[l]);
        prod[l]   <= slew_slope * $signed({1'b0, q_d[1][l][CHARGE_BITS-1:0]});
        t_d[3][l] <= t_next[l];
        t_d[4][l] <= t_d[3][l];
        t_d[5][l] <= t_d[4][l];
        uu[l]     <= usq[l][31:0];
        z[l]      <= zp[l][46:24];
        w[l]      <= wp[l][38:16];
        dr[l]     <= drp[l][23:12];
        tv[l]     <= exp2_tab({1'b0, idx[l]});
        n7[l]     <= w[l][22:16];
        e[l]      <= (n7[l] > 7'd16) ? 17'd0 : (m[l] >> n7[l][4:0]);
        g[l]      <= gp[l][31:16];
      end
      for (int s = 2; s <= NS; s++) begin
        q_d[s] <= q_d[s-1];
      end
      for (int l = 0; l < 2; l++) begin
        qa1[l]    <= horner_step(QUAD_K1, QUAD_K2, t_d[4][l]);
        qa0[6][l] <= horner_step(QUAD_K0, qa1[l], t_d[5][l]);
      end
      ca2    <= horner_step(CUBIC_K2, CUBIC_K3, t_d[3][0]);
      ca1    <= horner_step(CUBIC_K1, ca2, t_d[4][0]);
      ca0[6] <= horner_step(CUBIC_K0, ca1, t_d[5][0]);
      for (int s = 7; s <= NS; s++) begin
        qa0[s] <= qa0[s-1];
        ca0[s] <= ca0[s-1];
      end
    end
  end

  // The quadratic starts a stage later than the cubic, so both reach stage six together.
  always_comb begin
    push_item.q        = q_d[NS];
    push_item.g        = {g[2], g[1], g[0]};
    push_item.p0       = qa0[NS][0][ACC_W-1:16];
    push_item.p1       = qa0[NS][1][ACC_W-1:16];
    push_item.c0       = ca0[NS][ACC_W-1:16];
    push_item.zero_det = (g[0] == '0) || (g[1] == '0) || (g[2] == '0);
  end

endmodule
`default_nettype wire

### hdl/ppas_queue.sv
// Short register queue between the front and back pipelines.
`default_nettype none
module ppas_queue import ppas_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       nonempty
);

  localparam int PTRW = $clog2(FIFO_DEPTH);

  item_t mem [FIFO_DEPTH];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [PTRW:0]   count;

  assign full     = (count == (PTRW+1)'(FIFO_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

### hdl/ppas_div.sv
// Pipelined restoring divider giving a quotient saturated to 32 signed bits.
`default_nettype none
module ppas_div import ppas_pkg::*; (
  input  wire logic    clk,
  input  wire logic    en,
  input  wire div_in_t din,
  output div_out_t     dout
);

  typedef struct packed {
    logic [GW-1:0] rem;
    logic [31:0]   low;
    logic [31:0]   q;
    logic          ovf;
    logic          neg;
    logic [GW-1:0] d;
  } div_st_t;

  div_st_t st [0:DIV_STAGES];
  div_st_t nx [1:DIV_STAGES];
  div_st_t first;
  logic [MAG_W-33:0] hi;
  logic sat;

  // A quotient of 2^32 or more is flagged up front; the stages then see a remainder below d.
  always_comb begin
    hi          = din.mag[MAG_W-1:32];
    first.ovf   = (hi >= (MAG_W-32)'(din.d));
    first.rem   = hi[GW-1:0];
    first.low   = din.mag[31:0];
    first.q     = '0;
    first.neg   = din.neg;
    first.d     = din.d;
  end

  always_comb begin
    logic [GW:0] tt;
    logic        qb;
    tt = '0;
    qb = 1'b0;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      nx[j] = st[j-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        tt = {nx[j].rem, nx[j].low[31]};
        qb = (tt >= {1'b0, nx[j].d});
        nx[j].rem = qb ? GW'(tt - {1'b0, nx[j].d}) : tt[GW-1:0];
        nx[j].low = {nx[j].low[30:0], 1'b0};
        nx[j].q   = {nx[j].q[30:0], qb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= first;
      for (int j = 1; j <= DIV_STAGES; j++) begin
        st[j] <= nx[j];
      end
    end
  end

  assign sat = st[DIV_STAGES].ovf || st[DIV_STAGES].q[31];

  always_comb begin
    if (!st[DIV_STAGES].neg) begin
      dout.val = sat ? AMP_MAX : $signed(st[DIV_STAGES].q);
    end else begin
      dout.val = sat ? AMP_MIN : -$signed(st[DIV_STAGES].q);
    end
    dout.is_neg = st[DIV_STAGES].neg && (sat || (st[DIV_STAGES].q != '0));
  end

endmodule
`default_nettype wire

### hdl/ppas_back.sv
// Back pipeline: forward substitution through three dividers and the output register.
`default_nettype none
module ppas_back import ppas_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_nonempty,
  input  wire item_t        head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic signed [31:0] amp_early,
  output logic signed [31:0] amp_peak,
  output logic signed [31:0] amp_late,
  output logic              used_raw
);

  localparam int I_S0  = DIV_LAT + 1;
  localparam int I_M1  = I_S0 + 1;
  localparam int I_N1  = I_M1 + 1;
  localparam int I_S1  = I_N1 + DIV_LAT + 1;
  localparam int I_M2  = I_S1 + 1;
  localparam int I_N2  = I_M2 + 1;
  localparam int I_S2  = I_N2 + DIV_LAT + 1;
  localparam int I_OUT = I_S2 + 1;
  localparam int NB    = I_OUT + 1;

  typedef struct packed {
    item_t                   it;
    logic signed [AW-1:0]    s0;
    logic signed [AW-1:0]    s1;
    logic signed [AW-1:0]    s2;
    logic                    neg1;
    logic signed [PRODW-1:0] prod_a;
    logic signed [PRODW-1:0] prod_b;
    logic signed [PRODW-1:0] prod_c;
    logic                    num_neg;
    logic [MAG_W-1:0]        num_mag;
    logic                    raw;
  } bk_stage_t;

  bk_stage_t sb [NB];
  bk_stage_t nxt [NB];
  logic [NB-1:0] vb;
  logic adv;

  div_in_t  d0_in, d1_in, d2_in;
  div_out_t d0_out, d1_out, d2_out;

  assign adv = !vb[NB-1] || out_ready;
  assign pop = adv && q_nonempty;

  always_comb begin
    d0_in.neg = 1'b0;
    d0_in.mag = {(MAG_W-QW-16)'(0), sb[0].it.q[0], 16'd0};
    d0_in.d   = sb[0].it.g[0];
    d1_in.neg = sb[I_N1].num_neg;
    d1_in.mag = sb[I_N1].num_mag;
    d1_in.d   = sb[I_N1].it.g[1];
    d2_in.neg = sb[I_N2].num_neg;
    d2_in.mag = sb[I_N2].num_mag;
    d2_in.d   = sb[I_N2].it.g[2];
  end

  ppas_div u_div0 (.clk(clk), .en(adv), .din(d0_in), .dout(d0_out));
  ppas_div u_div1 (.clk(clk), .en(adv), .din(d1_in), .dout(d1_out));
  ppas_div u_div2 (.clk(clk), .en(adv), .din(d2_in), .dout(d2_out));

  always_comb begin
    logic signed [MAG_W-1:0] num;
    num = '0;
    nxt[0] = sb[0];
    nxt[0].it = head;
    for (int i = 1; i < NB; i++) begin
      nxt[i] = sb[i-1];
    end
    nxt[I_S0].s0 = d0_out.val;
    nxt[I_M1].prod_a = $signed(sb[I_M1-1].it.p0) * $signed(sb[I_M1-1].s0);
    nxt[I_M1].prod_b = $signed(sb[I_M1-1].it.c0) * $signed(sb[I_M1-1].s0);
    num = $signed({(MAG_W-QW-16)'(0), sb[I_N1-1].it.q[1], 16'd0})
          - MAG_W'(sb[I_N1-1].prod_a);
    nxt[I_N1].num_neg = num[MAG_W-1];
    nxt[I_N1].num_mag = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
    nxt[I_S1].s1   = d1_out.val;
    nxt[I_S1].neg1 = d1_out.is_neg;
    nxt[I_M2].prod_c = $signed(sb[I_M2-1].it.p1) * $signed(sb[I_M2-1].s1);
    num = $signed({(MAG_W-QW-16)'(0), sb[I_N2-1].it.q[2], 16'd0})
          - MAG_W'(sb[I_N2-1].prod_b) - MAG_W'(sb[I_N2-1].prod_c);
    nxt[I_N2].num_neg = num[MAG_W-1];
    nxt[I_N2].num_mag = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
    nxt[I_S2].s2 = d2_out.val;
    // Fall back to the raw charges when the system is singular or the middle pulse is negative.
    nxt[I_OUT].raw = sb[I_OUT-1].it.zero_det || sb[I_OUT-1].neg1;
    if (nxt[I_OUT].raw) begin
      for (int l = 0; l < 3; l++) begin
        if (sb[I_OUT-1].it.q[l][QW-1]) begin
          nxt[I_OUT].it.q[l] = AMP_MAX;
        end
      end
      nxt[I_OUT].s0 = $signed(nxt[I_OUT].it.q[0]);
      nxt[I_OUT].s1 = $signed(nxt[I_OUT].it.q[1]);
      nxt[I_OUT].s2 = $signed(nxt[I_OUT].it.q[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (adv) begin
      vb <= {vb[NB-2:0], q_nonempty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NB; i++) begin
        sb[i] <= nxt[i];
      end
    end
  end

  assign out_valid = vb[NB-1];
  assign amp_early = sb[NB-1].s0;
  assign amp_peak  = sb[NB-1].s1;
  assign amp_late  = sb[NB-1].s2;
  assign used_raw  = sb[NB-1].raw;

endmodule
`default_nettype wire

### hdl/pulse_pileup_amplitude_solver_unit.sv
// Path: the front pipeline, then the queue, then the back pipeline to the output register.
// Throughput: one beat per cycle while out_ready holds; every multiply and each divider is fully pipelined.
// The three dividers each retire four quotient bits per stage over eight stages.
// Reset is synchronous and active high; it empties the pipelines and queue and clears
// both slew registers to zero. Data registers are not reset.
`default_nettype none
module pulse_pileup_amplitude_solver_unit import ppas_pkg::*; #(
  parameter int CHARGE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CHARGE_BITS-1:0] early_charge,
  input  wire logic [CHARGE_BITS-1:0] peak_charge,
  input  wire logic [CHARGE_BITS-1:0] late_charge,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [31:0]          amp_early,
  output logic signed [31:0]          amp_peak,
  output logic signed [31:0]          amp_late,
  output logic                        used_raw,
  input  wire logic                   cfg_wen,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [23:0]            cfg_data
);

  logic signed [15:0] slew_offset;
  logic signed [23:0] slew_slope;
  logic  q_full, q_nonempty, push, pop;
  item_t push_item, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_offset <= '0;
      slew_slope  <= '0;
    end else if (cfg_wen && !cfg_index[1]) begin
      case (cfg_index[0])
        REG_SLEW_OFFSET: slew_offset <= cfg_data[15:0];
        REG_SLEW_SLOPE:  slew_slope  <= cfg_data;
        default: ;
      endcase
    end
  end

  ppas_front #(.CHARGE_BITS(CHARGE_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .early_charge(early_charge), .peak_charge(peak_charge), .late_charge(late_charge),
    .slew_offset(slew_offset), .slew_slope(slew_slope),
    .q_full(q_full), .push(push), .push_item(push_item)
  );

  ppas_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .pop(pop),
    .head(head), .full(q_full), .nonempty(q_nonempty)
  );

  ppas_back u_back (
    .clk(clk), .rst(rst), .q_nonempty(q_nonempty), .head(head), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .amp_early(amp_early), .amp_peak(amp_peak), .amp_late(amp_late), .used_raw(used_raw)
  );

endmodule
`default_nettype wire

### test/pulse_pileup_amplitude_solver_checker.sv
// Checker for the pile-up solver: predicts each amplitude beat from the charges and compares.
`default_nettype none
module pulse_pileup_amplitude_solver_checker import ppas_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [23:0]        early_charge,
  input  wire logic [23:0]        peak_charge,
  input  wire logic [23:0]        late_charge,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] amp_early,
  input  wire logic signed [31:0] amp_peak,
  input  wire logic signed [31:0] amp_late,
  input  wire logic               used_raw,
  input  wire logic               cfg_wen,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output int                      fails,
  output int                      pending,
  output int                      raw_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic               raw;
  } amps_t;

  localparam longint INT_MAX = 64'sd2147483647;
  localparam longint INT_MIN = -64'sd2147483648;

  amps_t amps_q[$];
  logic signed [15:0] offset_reg;
  logic signed [23:0] slope_reg;
  int n_in, n_out;

  assign pending = n_in - n_out;

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint slew(longint q);
    longint off, slp;
    off = longint'(offset_reg);
    slp = longint'(slope_reg);
    return clip(off + ((slp * q) >>> 20), -32768, 32767);
  endfunction

  function automatic longint pow2_neg(longint w);
    longint tab[17];
    longint n, f, idx, r, m;
    tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
            44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    n = w >> 16;
    f = w & 64'hFFFF;
    idx = f >> 12;
    r = f & 64'hFFF;
    if (n > 16) return 0;
    m = tab[idx] - (((tab[idx] - tab[idx+1]) * r) >> 12);
    return m >> n;
  endfunction

  function automatic longint gauss(longint t);
    longint u, z, w;
    u = t + 1324;
    z = (u * u * 56084) >> 24;
    w = (z * 94548) >> 16;
    return (46531 * pow2_neg(w)) >>> 16;
  endfunction

  function automatic longint quad(longint t);
    longint acc;
    acc = 2055571;
    acc = 76450418 + ((acc * t) >>> 8);
    acc = 1108101562 + ((acc * t) >>> 8);
    return acc >>> 16;
  endfunction

  function automatic longint cubic(longint t);
    longint acc;
    acc = 6335;
    acc = 360605 + ((acc * t) >>> 8);
    acc = 11755326 + ((acc * t) >>> 8);
    acc = 274491360 + ((acc * t) >>> 8);
    return acc >>> 16;
  endfunction

  function automatic amps_t solve_amps(longint q0, longint q1, longint q2);
    longint t0, t1, t2, g0, g1, g2, a0, a1, a2, s0, s1;
    amps_t res;
    t0 = slew(q0);
    t1 = slew(q1);
    t2 = slew(q2);
    g0 = gauss(t0);
    g1 = gauss(t1);
    g2 = gauss(t2);
    res.raw = 1'b0;
    if (g0 == 0 || g1 == 0 || g2 == 0) begin
      res.raw = 1'b1;
    end else begin
      a0 = (q0 * 65536) / g0;
      s0 = clip(a0, INT_MIN, INT_MAX);
      a1 = (q1 * 65536 - quad(t0) * s0) / g1;
      s1 = clip(a1, INT_MIN, INT_MAX);
      a2 = (q2 * 65536 - cubic(t0) * s0 - quad(t1) * s1) / g2;
      if (a1 < 0) res.raw = 1'b1;
    end
    if (res.raw) begin
      a0 = q0;
      a1 = q1;
      a2 = q2;
    end
    res.a0 = 32'(clip(a0, INT_MIN, INT_MAX));
    res.a1 = 32'(clip(a1, INT_MIN, INT_MAX));
    res.a2 = 32'(clip(a2, INT_MIN, INT_MAX));
    return res;
  endfunction

  always @(posedge clk) begin
    amps_t e;
    if (rst) begin
      offset_reg <= '0;
      slope_reg  <= '0;
      amps_q.delete();
      n_in <= 0;
      n_out <= 0;
      fails <= 0;
      raw_count <= 0;
    end else begin
      if (cfg_wen && cfg_index == {1'b0, REG_SLEW_OFFSET}) offset_reg <= cfg_data[15:0];
      if (cfg_wen && cfg_index == {1'b0, REG_SLEW_SLOPE}) slope_reg <= cfg_data;
      if (in_valid && in_ready) begin
        amps_q.insert(amps_q.size(), solve_amps(early_charge, peak_charge, late_charge));
        n_in <= n_in + 1;
      end
      if (out_valid && out_ready) begin
        n_out <= n_out + 1;
        raw_count <= raw_count + used_raw;
        if (amps_q.size() == 0) begin
          $display("%0t: unexpected beat amps %0d %0d %0d raw %0b", $time,
                   amp_early, amp_peak, amp_late, used_raw);
          fails <= fails + 1;
        end else begin
          e = amps_q.pop_front();
          if (e.a0 !== amp_early || e.a1 !== amp_peak || e.a2 !== amp_late
              || e.raw !== used_raw) begin
            $display("%0t: expected %0d %0d %0d raw %0b, got %0d %0d %0d raw %0b", $time,
                     e.a0, e.a1, e.a2, e.raw, amp_early, amp_peak, amp_late, used_raw);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### test/pulse_pileup_amplitude_solver_unit_test.sv
// Top of the pile-up solver testbench: clock, reset, charge stimulus and the verdict.
`default_nettype none
module pulse_pileup_amplitude_solver_unit_test import ppas_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic [23:0] QMAX = 24'hFFFFFF;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, used_raw, cfg_wen;
  logic [23:0] early_charge, peak_charge, late_charge, cfg_data;
  logic [1:0] cfg_index;
  logic signed [31:0] amp_early, amp_peak, amp_late;
  int fails, pending, raw_count, cycles, beats_sent;
  bit long_hold, steady;

  pulse_pileup_amplitude_solver_unit u_top (.*);
  pulse_pileup_amplitude_solver_checker u_check (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, mostly short, and a long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
        out_ready <= 1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else if (steady || $urandom_range(0, 9) < 7) begin
        out_ready <= 1;
      end else begin
        out_ready <= 0;
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
      end
    end
  end

  function automatic int pick_gap();
    if (steady) return 0;
    case ($urandom_range(0, 19))
      0: return $urandom_range(10, 40);
      1, 2, 3, 4: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge at which the beat is taken.
  task automatic offer_charges(input logic [23:0] e, input logic [23:0] p,
                               input logic [23:0] l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    early_charge <= e;
    peak_charge <= p;
    late_charge <= l;
    forever begin
      @(negedge clk);
      if (in_ready) begin
        @(posedge clk);
        break;
      end
    end
    beats_sent++;
  endtask

  function automatic logic [23:0] rand_charge();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 24'(QMAX) : 24'd0;
      1, 2, 3: return 24'($urandom_range(0, QMAX));
      4, 5: return 24'($urandom_range(0, 65535));
      default: return 24'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic drain_and_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  initial begin
    logic [15:0] offsets[8];
    logic [23:0] slopes[8];
    in_valid = 0;
    early_charge = 0;
    peak_charge = 0;
    late_charge = 0;
    cfg_wen = 0;
    cfg_index = 0;
    cfg_data = 0;
    cycles = 0;
    beats_sent = 0;
    long_hold = 0;
    steady = 0;
    rst = 1;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed beats at the reset settings: zero slew, so every fraction is finite.
    offer_charges(0, 0, 0);
    offer_charges(QMAX, QMAX, QMAX);
    offer_charges(QMAX, 0, 0);
    offer_charges(0, QMAX, 0);
    offer_charges(0, 0, QMAX);
    offer_charges(24'h555555, 24'hAAAAAA, 24'h555555);
    offer_charges(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    offer_charges(1600, 10, 50);
    offer_charges(16, 3200, 800);
    offer_charges(24'h800000, 1, 24'h7FFFFF);

    offsets = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFAD4, 16'hFAD4, 16'h0600, 16'h0, 16'h0};
    slopes  = '{24'h000000, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000,
                24'h000000, 24'h000000, 24'h000000};
    offsets[6] = 16'($urandom_range(0, 65535));
    slopes[6]  = 24'($urandom_range(0, QMAX));
    offsets[7] = 16'($urandom_range(0, 4096)) - 16'd3000;
    slopes[7]  = 24'($urandom_range(0, 4095)) - 24'd2048;

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_idle();
      write_reg({1'b0, REG_SLEW_OFFSET}, 24'(offsets[ph]));
      write_reg({1'b0, REG_SLEW_SLOPE}, slopes[ph]);
      if (ph >= 4 && ph < 7) begin
        // Some of these settings can saturate the slew; a few directed beats there.
        offer_charges(0, 0, 0);
        offer_charges(QMAX, QMAX, QMAX);
        offer_charges(1, QMAX, 1);
      end
      steady = (ph == 2);
      for (int k = 0; k < 190; k++) begin
        if (k == 40 && ph % 2 == 0) long_hold = 1;
        offer_charges(rand_charge(), rand_charge(), rand_charge());
      end
    end
    steady = 0;
    drain_and_idle();

    $display("%0d charge beats sent over 8 slew settings, %0d fell back to raw charges",
             beats_sent, raw_count);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching beats", fails);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

### pulse_pileup_amplitude_solver_unit.f
hdl/ppas_pkg.sv
hdl/ppas_front.sv
hdl/ppas_queue.sv
hdl/ppas_div.sv
hdl/ppas_back.sv
hdl/pulse_pileup_amplitude_solver_unit.sv
test/pulse_pileup_amplitude_solver_checker.sv
test/pulse_pileup_amplitude_solver_unit_test.sv
